/* rtl/core/gftt_pkg.sv */
// Shared types and codes for the pending fence table.
package gftt_pkg;

	localparam int DEPTH_DEFAULT = 16;

	// Operation codes
	localparam logic [1:0] FUNC_SUBMIT   = 2'd0;
	localparam logic [1:0] FUNC_CANCEL   = 2'd1;
	localparam logic [1:0] FUNC_COMPLETE = 2'd2;
	localparam logic [1:0] FUNC_CLEAR    = 2'd3;

	// One stored fence
	typedef struct packed {
		logic        is_ctx;
		logic [31:0] ctx;
		logic [7:0]  ring;
		logic [63:0] gen;
		logic [63:0] rid;
		logic [63:0] guest;
	} slot_entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic rd_en;
		logic eval;
		logic pass_b;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;
	} dp_stat_t;

endpackage

/* rtl/core/gftt_ctrl.sv */
// Sequencer that sweeps the table one slot per cycle, in one or two passes.
module gftt_ctrl
	import gftt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	localparam int IW = $clog2(TABLE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    func,
	input  dp_stat_t      stat,
	output logic          busy,
	output dp_cmd_t       cmd,
	output logic [IW-1:0] rd_idx,
	output logic [IW-1:0] eval_idx
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0]    state_q;
	logic [IW:0]   cnt_q;
	logic          eval_s1;
	logic [IW-1:0] eval_idx_s1;
	logic          pass_b_q;
	logic [1:0]    func_q;
	logic          rd_en;
	logic          last_eval;
	logic          go_b;

	assign busy      = (state_q != ST_IDLE);
	assign rd_en     = (state_q == ST_SCAN) && (cnt_q < (IW+1)'(TABLE_DEPTH));
	assign rd_idx    = cnt_q[IW-1:0];
	assign eval_idx  = eval_idx_s1;
	assign last_eval = eval_s1 && (eval_idx_s1 == IW'(TABLE_DEPTH - 1));
	assign go_b      = (func_q == FUNC_COMPLETE) && !pass_b_q && stat.hit;

	// Drive datapath commands
	always_comb begin
		cmd.load   = start && !busy;
		cmd.rd_en  = rd_en;
		cmd.eval   = eval_s1;
		cmd.pass_b = pass_b_q;
		cmd.finish = (state_q == ST_CHECK) && !go_b;
	end

	// Advance the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			eval_s1  <= 1'b0;
			pass_b_q <= 1'b0;
			func_q   <= FUNC_SUBMIT;
		end else begin
			eval_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q   <= func;
						pass_b_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_eval) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (go_b) begin
						pass_b_q <= 1'b1;
						cnt_q    <= '0;
						state_q  <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Track the slot whose read data is in flight
	always_ff @(posedge clk) begin
		eval_idx_s1 <= cnt_q[IW-1:0];
	end

endmodule

/* rtl/core/gftt_dp.sv */
// Slot memory, valid bits, id counters and per-slot evaluation.
module gftt_dp
	import gftt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT,
	localparam int IW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	input  logic [IW-1:0] rd_idx,
	input  logic [IW-1:0] eval_idx,
	input  logic [1:0]    func,
	input  logic          is_context_fence,
	input  logic [31:0]   context_id,
	input  logic [7:0]    ring_index,
	input  logic [63:0]   batch_generation,
	input  logic [63:0]   guest_id,
	input  logic [63:0]   target_id,
	output dp_stat_t      stat,
	output logic          done,
	output logic          ok,
	output logic [63:0]   assigned_id,
	output logic [63:0]   done_generation,
	output logic [63:0]   done_guest_id,
	output logic [4:0]    pending_count
);

	slot_entry_t mem [TABLE_DEPTH];
	slot_entry_t rd_s1;

	logic [TABLE_DEPTH-1:0] active_q;
	logic [CW-1:0]          count_q;
	logic [31:0]            gctr_q;
	logic [63:0]            cctr_q;

	// Latched operands
	logic [1:0]    func_q;
	logic          ctx_q;
	logic [31:0]   cid_q;
	logic [7:0]    ring_q;
	logic [63:0]   gen_q;
	logic [63:0]   guest_q;
	logic [63:0]   target_q;
	logic [63:0]   assigned_q;

	// Search results
	logic          hit_q;
	logic [IW-1:0] best_idx_q;
	logic [63:0]   best_id_q;
	logic [63:0]   best_gen_q;
	logic [63:0]   best_guest_q;

	logic [31:0] gnext;
	logic [63:0] cnext;
	logic        act;
	logic        match;
	logic        do_set;
	logic        do_drop;
	logic        take_best;
	logic [31:0] cnt_ext;

	assign stat.hit = hit_q;

	// Allocate next ids, skipping zero on wrap
	always_comb begin
		gnext = gctr_q + 32'd1;
		if (gnext == 32'd0) begin
			gnext = 32'd1;
		end
		cnext = cctr_q + 64'd1;
		if (cnext == 64'd0) begin
			cnext = 64'd1;
		end
	end

	// Evaluate the slot whose data just came out of memory
	always_comb begin
		act       = active_q[eval_idx];
		match     = act && (rd_s1.is_ctx == ctx_q) &&
			(!ctx_q || ((rd_s1.ctx == cid_q) && (rd_s1.ring == ring_q)));
		do_set    = 1'b0;
		do_drop   = 1'b0;
		take_best = 1'b0;
		if (cmd.eval) begin
			unique case (func_q)
				FUNC_SUBMIT: do_set = !act && !hit_q;
				FUNC_CANCEL: do_drop = match && (rd_s1.rid == target_q) && !hit_q;
				FUNC_COMPLETE: begin
					if (cmd.pass_b) begin
						do_drop = (act && (eval_idx == best_idx_q)) ||
							(match && (rd_s1.gen == best_gen_q) && (rd_s1.rid <= target_q));
					end else begin
						take_best = match && (rd_s1.rid <= target_q) &&
							(!hit_q || (rd_s1.rid >= best_id_q));
					end
				end
				FUNC_CLEAR: ;
				default: ;
			endcase
		end
	end

	// Write the new fence into the free slot, read one slot per cycle
	always_ff @(posedge clk) begin
		if (do_set) begin
			mem[eval_idx] <= '{is_ctx: ctx_q, ctx: ctx_q ? cid_q : 32'd0,
				ring: ctx_q ? ring_q : 8'd0, gen: gen_q, rid: assigned_q, guest: guest_q};
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[rd_idx];
		end
	end

	// Latch operands at the accepted beat, and the best match during the first pass
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			ctx_q    <= is_context_fence;
			cid_q    <= context_id;
			ring_q   <= ring_index;
			gen_q    <= batch_generation;
			guest_q  <= guest_id;
			target_q <= target_id;
		end
		if (take_best) begin
			best_idx_q   <= eval_idx;
			best_id_q    <= rd_s1.rid;
			best_gen_q   <= rd_s1.gen;
			best_guest_q <= rd_s1.guest;
		end
	end

	// Hold table state, counters and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			count_q    <= '0;
			gctr_q     <= '0;
			cctr_q     <= '0;
			hit_q      <= 1'b0;
			assigned_q <= '0;
			done       <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.load) begin
				hit_q      <= 1'b0;
				assigned_q <= '0;
				unique case (func)
					FUNC_SUBMIT: begin
						if (is_context_fence) begin
							cctr_q     <= cnext;
							assigned_q <= cnext;
						end else begin
							gctr_q     <= gnext;
							assigned_q <= {32'd0, gnext};
						end
					end
					FUNC_CLEAR: begin
						active_q <= '0;
						count_q  <= '0;
						hit_q    <= 1'b1;
					end
					default: ;
				endcase
			end
			if (do_set) begin
				active_q[eval_idx] <= 1'b1;
				count_q            <= count_q + 1'b1;
				hit_q              <= 1'b1;
			end
			if (do_drop) begin
				active_q[eval_idx] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
				if (!cmd.pass_b) begin
					hit_q <= 1'b1;
				end
			end
			if (take_best) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign cnt_ext = 32'(count_q);

	// Register the result beat
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ok            <= hit_q;
			assigned_id   <= assigned_q;
			done_generation <= (hit_q && (func_q == FUNC_COMPLETE)) ? best_gen_q : 64'd0;
			done_guest_id <= (hit_q && (func_q == FUNC_COMPLETE)) ? best_guest_q : 64'd0;
			pending_count <= cnt_ext[4:0];
		end
	end

endmodule

/* rtl/core/gpu_fence_tracking_table_top.sv */
// Top level of the pending fence table: sequencer plus datapath.
// One operation is taken when start is high and busy is low. The table is
// swept one slot per cycle through a slot memory with a write port and a
// registered read port. Submit, cancel and clear take one sweep; a complete
// that finds an entry takes a second sweep. The result beat shows for one
// cycle with done high and cannot be stalled; a new start may be given in
// that same cycle.
module gpu_fence_tracking_table_top
	import gftt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic        is_context_fence,
	input  logic [31:0] context_id,
	input  logic [7:0]  ring_index,
	input  logic [63:0] batch_generation,
	input  logic [63:0] guest_id,
	input  logic [63:0] target_id,
	output logic        done,
	output logic        ok,
	output logic [63:0] assigned_id,
	output logic [63:0] done_generation,
	output logic [63:0] done_guest_id,
	output logic [4:0]  pending_count
);

	localparam int IW = $clog2(TABLE_DEPTH);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] eval_idx;

	gftt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.func     (func),
		.stat     (stat),
		.busy     (busy),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.eval_idx (eval_idx)
	);

	gftt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.rd_idx           (rd_idx),
		.eval_idx         (eval_idx),
		.func             (func),
		.is_context_fence (is_context_fence),
		.context_id       (context_id),
		.ring_index       (ring_index),
		.batch_generation (batch_generation),
		.guest_id         (guest_id),
		.target_id        (target_id),
		.stat             (stat),
		.done             (done),
		.ok               (ok),
		.assigned_id      (assigned_id),
		.done_generation  (done_generation),
		.done_guest_id    (done_guest_id),
		.pending_count    (pending_count)
	);

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result beat without an operation");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy) else $error("accepted beat did not start a sweep");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ((done_generation == 64'd0) && (done_guest_id == 64'd0)))
		else $error("failed operation reported a completed fence");
`endif

endmodule
